// ===== design/pjs_pkg.sv =====
// Package for the parallel job scheduler.
// Holds the fixed field widths, the register map and the cell control struct.
// No dependencies; used by pjs_cell and parallel_job_scheduler.
package pjs_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_W  = 48;
  localparam int DUR_W   = 32;
  localparam int CFG_W   = 7;
  localparam int WIDX_W  = 6;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Register map, as register indexes.
  localparam logic REG_WORKER_COUNT = 1'b0;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic pop;      // a job transaction is taken: remove head, insert new key
    logic restart;  // every worker restarts at time zero
  } cell_ctrl_t;

endpackage

// ===== design/pjs_cell.sv =====
// One cell of the sorted worker chain of the parallel job scheduler.
// Holds one (free time, index) entry and takes its neighbour's or the new key.
// Depends on pjs_pkg.
module pjs_cell #(
  parameter int IDX_W = 6
) (
  input  logic                      clk,
  input  pjs_pkg::cell_ctrl_t       ctrl,
  input  logic                      active,
  input  logic                      first,
  input  logic [IDX_W-1:0]          init_index,
  input  logic [pjs_pkg::TIME_W-1:0] key_time,
  input  logic [IDX_W-1:0]          key_index,
  input  logic [pjs_pkg::TIME_W-1:0] nxt_time,
  input  logic [IDX_W-1:0]          nxt_index,
  input  logic                      nxt_lt,
  output logic [pjs_pkg::TIME_W-1:0] cell_time,
  output logic [IDX_W-1:0]          cell_index,
  output logic                      lt
);

  logic own_lt;
  logic [pjs_pkg::TIME_W-1:0] cell_time_next;
  logic [IDX_W-1:0]           cell_index_next;

  // Lexicographic order on (free time, index); inactive cells never precede.
  always_comb begin
    own_lt = (cell_time < key_time) ||
             ((cell_time == key_time) && (cell_index < key_index));
    lt = active && own_lt;
  end

  // Shift left past a smaller neighbour, otherwise take the key at its slot.
  always_comb begin
    cell_time_next  = cell_time;
    cell_index_next = cell_index;
    if (ctrl.restart) begin
      cell_time_next  = '0;
      cell_index_next = init_index;
    end else if (ctrl.pop && active) begin
      if (nxt_lt) begin
        cell_time_next  = nxt_time;
        cell_index_next = nxt_index;
      end else if (first || own_lt) begin
        cell_time_next  = key_time;
        cell_index_next = key_index;
      end
    end
  end

  // Entry storage; the restart command puts it in its reset value.
  always_ff @(posedge clk) begin
    cell_time  <= cell_time_next;
    cell_index <= cell_index_next;
  end

endmodule

// ===== design/parallel_job_scheduler.sv =====
// Top level of the parallel job scheduler: APB register, job port, cell chain.
// Depends on pjs_pkg and pjs_cell.
//
//   channel  | handshake                         | payload
//   ---------+-----------------------------------+------------------------------
//   job      | start && !busy                    | job_duration
//   result   | done (one cycle, no back-pressure)| worker_index, start_time
//   config   | psel && penable && pwrite && pready| paddr, pwdata (prdata read)
//
// A job is taken in any cycle and its result shows in the next cycle, so one
// job per cycle is sustained; the chain removes the head and inserts the
// updated key in the same register update. busy is never raised.
// Reset (synchronous, rst) and a write of worker_count put every worker at
// time zero; the result side cannot be stalled.
module parallel_job_scheduler #(
  parameter int MAX_WORKERS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pjs_pkg::APB_AW-1:0]    paddr,
  input  logic [pjs_pkg::APB_DW-1:0]    pwdata,
  output logic [pjs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [pjs_pkg::DUR_W-1:0]     job_duration,
  output logic                          done,
  output logic [pjs_pkg::WIDX_W-1:0]    worker_index,
  output logic [pjs_pkg::TIME_W-1:0]    start_time
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);
  localparam int RESET_COUNT = (MAX_WORKERS < 64) ? MAX_WORKERS : 64;

  logic [CNT_W-1:0] worker_count;
  logic [CNT_W-1:0] worker_count_next;
  logic             cfg_write;
  logic             job_take;
  logic [pjs_pkg::CFG_W-1:0] cfg_value;

  logic [pjs_pkg::TIME_W-1:0] cell_time  [MAX_WORKERS];
  logic [IDX_W-1:0]           cell_index [MAX_WORKERS];
  logic [MAX_WORKERS-1:0]     cell_lt;
  logic [MAX_WORKERS-1:0]     cell_active;

  logic [pjs_pkg::TIME_W:0]   key_sum;
  logic [pjs_pkg::TIME_W-1:0] key_time;
  pjs_pkg::cell_ctrl_t        ctrl;

  // Configuration port: always ready, one register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[2] == pjs_pkg::REG_WORKER_COUNT);
  assign cfg_value = pwdata[pjs_pkg::CFG_W-1:0];
  assign prdata    = pjs_pkg::APB_DW'(worker_count);

  // Clamp the written count into one to MAX_WORKERS.
  always_comb begin
    if (cfg_value == '0) begin
      worker_count_next = CNT_W'(1);
    end else if (32'(cfg_value) > MAX_WORKERS) begin
      worker_count_next = CNT_W'(MAX_WORKERS);
    end else begin
      worker_count_next = CNT_W'(cfg_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= CNT_W'(RESET_COUNT);
    end else if (cfg_write) begin
      worker_count <= worker_count_next;
    end
  end

  // Job transaction: the key is the head's free time plus duration, saturated.
  assign busy     = 1'b0;
  assign job_take = start && !busy;
  assign key_sum  = {1'b0, cell_time[0]} + (pjs_pkg::TIME_W + 1)'(job_duration);
  assign key_time = key_sum[pjs_pkg::TIME_W] ? pjs_pkg::TIME_MAX
                                             : key_sum[pjs_pkg::TIME_W-1:0];

  assign ctrl.restart = rst || cfg_write;
  assign ctrl.pop     = job_take;

  // Row of cells, kept sorted by (free time, index) with the head in cell zero.
  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    logic [pjs_pkg::TIME_W-1:0] nxt_time;
    logic [IDX_W-1:0]           nxt_index;
    logic                       nxt_lt;

    assign cell_active[i] = (CNT_W'(i) < worker_count);

    if (i == MAX_WORKERS - 1) begin : g_last
      assign nxt_time  = '0;
      assign nxt_index = '0;
      assign nxt_lt    = 1'b0;
    end else begin : g_mid
      assign nxt_time  = cell_time[i+1];
      assign nxt_index = cell_index[i+1];
      assign nxt_lt    = cell_lt[i+1];
    end

    pjs_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .active    (cell_active[i]),
      .first     (i == 0),
      .init_index(IDX_W'(i)),
      .key_time  (key_time),
      .key_index (cell_index[0]),
      .nxt_time  (nxt_time),
      .nxt_index (nxt_index),
      .nxt_lt    (nxt_lt),
      .cell_time (cell_time[i]),
      .cell_index(cell_index[i]),
      .lt        (cell_lt[i])
    );
  end

  // Result register: the head as it stood when the job was taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= job_take;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      worker_index <= pjs_pkg::WIDX_W'(cell_index[0]);
      start_time   <= cell_time[0];
    end
  end

`ifndef SYNTH
  // Every taken job gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    job_take |=> done)
    else $error("job taken without a result in the next cycle");

  // No result appears without a job transaction before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(job_take))
    else $error("result without a job transaction");

  // The head never orders after the second active cell.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (worker_count > CNT_W'(1)) |-> !cell_lt[1] || (cell_time[1] == cell_time[0] &&
      cell_index[1] > cell_index[0]) || (cell_time[1] > cell_time[0]))
    else $error("cell chain out of order at the head");
`endif

endmodule
